>>> rtl/pcsb_pkg.sv
// Shared types, constants and trig tables for the point-to-scan-bin block.
// No dependencies; every other file in rtl/ uses this package.
package pcsb_pkg;

  localparam int NUM_BINS  = 360;
  localparam int BIN_W     = 9;
  localparam int COORD_W   = 18;
  localparam int HGT_W     = 18;
  localparam int RANGE_W   = 16;
  localparam int SQ_W      = 36;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int TAB_W     = 32;
  localparam int PROD_W    = COORD_W + TAB_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_RANGE = 2'd2;

  localparam logic signed [HGT_W-1:0] MIN_HEIGHT_RST  = -18'sd131072;
  localparam logic signed [HGT_W-1:0] MAX_HEIGHT_RST  = 18'sd131071;
  localparam logic [RANGE_W-1:0]      EMPTY_RANGE_RST = 16'd11000;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam int     TAYLOR_TERMS = 13;

  // Taylor term denominators: (2n+2)(2n+3) for sine, (2n+1)(2n+2) for cosine
  localparam longint SIN_DEN [TAYLOR_TERMS] = '{
    6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702
  };
  localparam longint COS_DEN [TAYLOR_TERMS] = '{
    2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650
  };

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_FARTHER = 3'd1,
    ST_INVALID = 3'd2,
    ST_HEIGHT  = 3'd3,
    ST_ANGLE   = 3'd4,
    ST_READ    = 3'd5
  } status_e;

  typedef logic signed [TAB_W-1:0] trig_tab_t [NUM_BINS];

  // cos/sin of bin edge angles in Q30, Taylor series about pi/2, truncating divides
  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t t;
    longint    a, b, b2, ts, tc, ss, cs;
    t[0] = want_sin ? '0 : TAB_W'(ONE_Q30);
    for (int k = 1; k < NUM_BINS; k++) begin
      a  = (longint'(k) * PI_Q30) / NUM_BINS;
      b  = a - HALF_PI_Q30;
      b2 = (b * b) / ONE_Q30;
      ts = b;
      tc = ONE_Q30;
      ss = 0;
      cs = 0;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        ss = ss + ts;
        cs = cs + tc;
        ts = -((ts * b2) / ONE_Q30) / SIN_DEN[n];
        tc = -((tc * b2) / ONE_Q30) / COS_DEN[n];
      end
      t[k] = want_sin ? TAB_W'(cs) : TAB_W'(-ss);
    end
    return t;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage

>>> rtl/pcsb_if.sv
// Valid/ready channel interfaces for point requests and bin results.
// Depends on pcsb_pkg.
interface pcsb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic signed [pcsb_pkg::COORD_W-1:0]   x_mm;
  logic signed [pcsb_pkg::COORD_W-1:0]   y_mm;
  logic signed [pcsb_pkg::COORD_W-1:0]   z_mm;
  logic                                  point_valid;
  logic        [pcsb_pkg::BIN_W-1:0]     read_bin;
  modport source (output valid, opcode, x_mm, y_mm, z_mm, point_valid, read_bin,
                  input ready);
  modport sink   (input valid, opcode, x_mm, y_mm, z_mm, point_valid, read_bin,
                  output ready);
endinterface

interface pcsb_out_if;
  logic                              valid;
  logic                              ready;
  pcsb_pkg::status_e                 status;
  logic [pcsb_pkg::BIN_W-1:0]        bin_index;
  logic [pcsb_pkg::RANGE_W-1:0]      range_mm;
  modport source (output valid, status, bin_index, range_mm, input ready);
  modport sink   (input valid, status, bin_index, range_mm, output ready);
endinterface

>>> rtl/pcsb_bin_ram.sv
// Bin range store: single-port synchronous RAM, registered read.
// Depends on pcsb_pkg.
module pcsb_bin_ram (
  input  logic                          clk_i,
  input  logic [pcsb_pkg::BIN_W-1:0]    addr_i,
  input  logic                          we_i,
  input  logic [pcsb_pkg::RANGE_W-1:0]  wdata_i,
  output logic [pcsb_pkg::RANGE_W-1:0]  rdata_o
);
  import pcsb_pkg::*;

  logic [RANGE_W-1:0] mem_q [NUM_BINS];
  logic [RANGE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pcsb_angle.sv
// Angle binning: bitwise search over the bin edges, sign of z*cos - x*sin.
// Trig constants come from a pcsb_pkg ROM; per bit: ROM read, multiply, compare.
module pcsb_angle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [pcsb_pkg::COORD_W-1:0] x_i,
  input  logic signed [pcsb_pkg::COORD_W-1:0] z_i,
  output logic                               done_o,
  output logic [pcsb_pkg::BIN_W-1:0]         idx_o
);
  import pcsb_pkg::*;

  localparam logic [1:0] PH_ROM = 2'd0;
  localparam logic [1:0] PH_MUL = 2'd1;
  localparam logic [1:0] PH_CMP = 2'd2;

  logic                      busy_q, done_q;
  logic [1:0]                phase_q;
  logic [BIN_W-1:0]          cnt_q, bit_q, cand, rom_addr;
  logic                      cand_ok;
  logic signed [COORD_W-1:0] x_q, z_q;
  logic signed [TAB_W-1:0]   cos_q, sin_q;
  logic signed [PROD_W-1:0]  zc_q, xs_q;
  logic signed [PROD_W:0]    diff;

  assign cand     = cnt_q | bit_q;
  assign cand_ok  = {1'b0, cand} < (BIN_W + 1)'(NUM_BINS);
  assign rom_addr = cand_ok ? cand : '0;
  assign diff     = (PROD_W + 1)'(zc_q) - (PROD_W + 1)'(xs_q);

  always_ff @(posedge clk_i) begin
    cos_q <= COS_TAB[rom_addr];
    sin_q <= SIN_TAB[rom_addr];
    zc_q  <= PROD_W'(z_q) * PROD_W'(cos_q);
    xs_q  <= PROD_W'(x_q) * PROD_W'(sin_q);
    if (start_i) begin
      x_q <= x_i;
      z_q <= z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_ROM;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= PH_ROM;
        cnt_q   <= '0;
        bit_q   <= {1'b1, {(BIN_W - 1){1'b0}}};
      end else if (busy_q) begin
        case (phase_q)
          PH_ROM:  phase_q <= PH_MUL;
          PH_MUL:  phase_q <= PH_CMP;
          PH_CMP: begin
            if (cand_ok && !diff[PROD_W]) begin
              cnt_q <= cand;
            end
            bit_q   <= bit_q >> 1;
            phase_q <= PH_ROM;
            if (bit_q[0]) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: phase_q <= PH_ROM;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign idx_o  = cnt_q;

endmodule

>>> rtl/pcsb_isqrt.sv
// Range unit: registered squares, then floor(sqrt(x^2+z^2)) one root bit a cycle.
// Depends on pcsb_pkg.
module pcsb_isqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pcsb_pkg::COORD_W-1:0] x_i,
  input  logic signed [pcsb_pkg::COORD_W-1:0] z_i,
  output logic                                done_o,
  output logic [pcsb_pkg::ROOT_W-1:0]         root_o
);
  import pcsb_pkg::*;

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_MUL  = 2'd1;
  localparam logic [1:0] SQ_SUM  = 2'd2;
  localparam logic [1:0] SQ_RUN  = 2'd3;

  logic [1:0]                state_q;
  logic                      done_q;
  logic signed [COORD_W-1:0] x_q, z_q;
  logic signed [SQ_W-1:0]    xx_q, zz_q;
  logic [SQ_W-1:0]           v_q, res_q, bit_q;
  logic [SQ_W:0]             trial;
  logic                      take;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = {1'b0, v_q} >= trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      z_q <= z_i;
    end
    xx_q <= SQ_W'(x_q) * SQ_W'(x_q);
    zz_q <= SQ_W'(z_q) * SQ_W'(z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
      v_q     <= '0;
      res_q   <= '0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SQ_IDLE: if (start_i) state_q <= SQ_MUL;
        SQ_MUL:  state_q <= SQ_SUM;
        SQ_SUM: begin
          v_q     <= SQ_W'(xx_q) + SQ_W'(zz_q);
          res_q   <= '0;
          bit_q   <= {2'b01, {(SQ_W - 2){1'b0}}};
          state_q <= SQ_RUN;
        end
        SQ_RUN: begin
          if (take) begin
            v_q   <= v_q - trial[SQ_W-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= SQ_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

>>> rtl/point_cloud_to_scan_bins_top.sv
// Point cloud to half-circle scan bins, top level.
// Depends on pcsb_pkg, pcsb_if, pcsb_bin_ram, pcsb_angle, pcsb_isqrt.
//
// in_if carries one request: opcode 0 adds a point (x, y, z in signed mm),
// opcode 1 reads one bin and sets it back to empty_range. out_if returns
// exactly one result per request: status, bin index and range in mm. The user
// must write registers (cfg_we_i/cfg_idx_i/cfg_data_i) while idle; unchecked.
//
// One request is worked on at a time. An accepted point runs a 9-bit search
// over the bin edges (per bit: ROM read, multiply, compare) next to a
// bit-serial square root; the next request is taken from the cycle in which
// the result turns valid. A read of a stored bin passes T_RDBIN, then T_OUT;
// a rejected point or a read past the last bin goes straight to T_OUT. The bin
// store is one RAM that is read, compared and written back per binned point.
// After reset every bin of the RAM is swept to 11000 mm with in_if.ready low;
// configuration writes are taken during the sweep.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result holds until out_if.ready takes the previous one.
module point_cloud_to_scan_bins_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pcsb_in_if.sink                           in_if,
  pcsb_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [pcsb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcsb_pkg::CFG_W-1:0]        cfg_data_i
);
  import pcsb_pkg::*;

  localparam logic [2:0] T_CLEAR = 3'd0;
  localparam logic [2:0] T_IDLE  = 3'd1;
  localparam logic [2:0] T_RDBIN = 3'd2;
  localparam logic [2:0] T_CALC  = 3'd3;
  localparam logic [2:0] T_CMP   = 3'd4;
  localparam logic [2:0] T_OUT   = 3'd5;

  logic [2:0]                state_q;
  logic [BIN_W-1:0]          clr_q;
  logic                      ang_flag_q, sq_flag_q, out_valid_q;
  logic signed [HGT_W-1:0]   min_h_q, max_h_q;
  logic [RANGE_W-1:0]        empty_q;

  logic [BIN_W-1:0]          bin_q;
  logic [ROOT_W-1:0]         root_q;
  status_e                   st_status_q, out_status_q;
  logic [BIN_W-1:0]          st_bin_q, out_bin_q;
  logic [RANGE_W-1:0]        st_range_q, out_range_q;

  logic                      accept, is_read, rd_in_range, hgt_bad, start_calc;
  logic signed [HGT_W:0]     hgt;
  logic signed [COORD_W-1:0] zz;
  logic [BIN_W-1:0]          ram_addr;
  logic                      ram_we;
  logic [RANGE_W-1:0]        ram_wdata, ram_rdata;
  logic                      ang_done, sq_done, closer, out_free;
  logic [BIN_W-1:0]          ang_idx;
  logic [ROOT_W-1:0]         sq_root;
  logic [RANGE_W-1:0]        root_sat;

  assign accept      = in_if.valid && (state_q == T_IDLE);
  assign is_read     = in_if.opcode;
  assign rd_in_range = {1'b0, in_if.read_bin} < (BIN_W + 1)'(NUM_BINS);
  assign hgt         = -$signed({in_if.y_mm[COORD_W-1], in_if.y_mm});
  assign hgt_bad     = (hgt < (HGT_W + 1)'(min_h_q)) || (hgt > (HGT_W + 1)'(max_h_q));
  assign zz          = ((in_if.x_mm == '0) && (in_if.z_mm == '0)) ? COORD_W'(1) : in_if.z_mm;
  assign start_calc  = accept && !is_read && in_if.point_valid && !hgt_bad
                       && !in_if.z_mm[COORD_W-1];
  assign out_free    = !out_valid_q || out_if.ready;

  assign closer   = {{(ROOT_W - RANGE_W){1'b0}}, ram_rdata} > root_q;
  assign root_sat = (root_q > ROOT_W'({RANGE_W{1'b1}})) ? {RANGE_W{1'b1}}
                                                        : root_q[RANGE_W-1:0];

  always_comb begin
    ram_addr  = bin_q;
    ram_we    = 1'b0;
    ram_wdata = empty_q;
    case (state_q)
      T_CLEAR: begin
        ram_addr  = clr_q;
        ram_we    = 1'b1;
        ram_wdata = EMPTY_RANGE_RST;
      end
      T_IDLE:  ram_addr = in_if.read_bin;
      T_RDBIN: ram_we = 1'b1;
      T_CMP: begin
        ram_we    = closer;
        ram_wdata = root_q[RANGE_W-1:0];
      end
      default: ram_addr = bin_q;
    endcase
  end

  pcsb_bin_ram u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  pcsb_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_calc),
    .x_i     (in_if.x_mm),
    .z_i     (zz),
    .done_o  (ang_done),
    .idx_o   (ang_idx)
  );

  pcsb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_calc),
    .x_i     (in_if.x_mm),
    .z_i     (in_if.z_mm),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_CLEAR;
      clr_q       <= '0;
      ang_flag_q  <= 1'b0;
      sq_flag_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_h_q     <= MIN_HEIGHT_RST;
      max_h_q     <= MAX_HEIGHT_RST;
      empty_q     <= EMPTY_RANGE_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_HEIGHT:  min_h_q <= cfg_data_i[HGT_W-1:0];
          CFG_MAX_HEIGHT:  max_h_q <= cfg_data_i[HGT_W-1:0];
          CFG_EMPTY_RANGE: empty_q <= cfg_data_i[RANGE_W-1:0];
          default:         ;
        endcase
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ang_done) ang_flag_q <= 1'b1;
      if (sq_done)  sq_flag_q  <= 1'b1;
      case (state_q)
        T_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BIN_W'(NUM_BINS - 1)) state_q <= T_IDLE;
        end
        T_IDLE: begin
          if (accept) begin
            if (start_calc)                state_q <= T_CALC;
            else if (is_read && rd_in_range) state_q <= T_RDBIN;
            else                           state_q <= T_OUT;
          end
        end
        T_RDBIN: state_q <= T_OUT;
        T_CALC: begin
          if (ang_flag_q && sq_flag_q) begin
            ang_flag_q <= 1'b0;
            sq_flag_q  <= 1'b0;
            state_q    <= T_CMP;
          end
        end
        T_CMP: state_q <= T_OUT;
        T_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ang_done) bin_q  <= ang_idx;
    if (sq_done)  root_q <= sq_root;
    if (accept) begin
      st_bin_q   <= '0;
      st_range_q <= '0;
      if (is_read) begin
        bin_q       <= in_if.read_bin;
        st_status_q <= ST_READ;
        st_bin_q    <= in_if.read_bin;
        st_range_q  <= empty_q;
      end else if (!in_if.point_valid) begin
        st_status_q <= ST_INVALID;
      end else if (hgt_bad) begin
        st_status_q <= ST_HEIGHT;
      end else if (in_if.z_mm[COORD_W-1]) begin
        st_status_q <= ST_ANGLE;
      end
    end
    if (state_q == T_RDBIN) begin
      st_range_q <= ram_rdata;
    end
    if (state_q == T_CMP) begin
      st_status_q <= closer ? ST_UPDATED : ST_FARTHER;
      st_bin_q    <= bin_q;
      st_range_q  <= root_sat;
    end
    if ((state_q == T_OUT) && out_free) begin
      out_status_q <= st_status_q;
      out_bin_q    <= st_bin_q;
      out_range_q  <= st_range_q;
    end
  end

  assign in_if.ready      = (state_q == T_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.status    = out_status_q;
  assign out_if.bin_index = out_bin_q;
  assign out_if.range_mm  = out_range_q;

  // the RAM is only written by the sweep, a read-and-clear or a closer hit
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == T_CLEAR || state_q == T_RDBIN || state_q == T_CMP))
    else $error("bin RAM written outside sweep, read or update");

  // an update only ever lowers the stored range
  a_update_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == T_CMP) |-> (ram_wdata < ram_rdata))
    else $error("bin update does not lower the range");

  // the compute units finish only while a point is being worked on
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_done || sq_done) |-> (state_q == T_CALC))
    else $error("angle or range unit finished outside a point request");

  // a new result is only loaded from the staging state
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == T_OUT))
    else $error("result appeared without a staged request");

endmodule

>>> verif/testbench.sv
// Self-checking bench for point_cloud_to_scan_bins_top: directed table, then random phases.
// Depends on rtl/pcsb_pkg.sv, rtl/pcsb_if.sv and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import pcsb_pkg::*;

  localparam int DRAIN_CYC = 50;
  localparam int LONG_HOLD = 300;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    status_e          status;
    logic [BIN_W-1:0] bin_index;
    logic [RANGE_W-1:0] range_mm;
  } scan_res_t;

  typedef struct {
    row_kind_e                  kind;
    logic                       opcode;
    logic signed [COORD_W-1:0]  x, y, z;
    logic                       pvalid;
    logic [BIN_W-1:0]           rbin;
    logic [CFG_IDX_W-1:0]       cidx;
    logic [CFG_W-1:0]           cval;
    bit                         fixed;
    scan_res_t                  res;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pcsb_in_if  req_if ();
  pcsb_out_if res_if ();

  point_cloud_to_scan_bins_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_if.sink),
    .out_if     (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the block
  longint    cos_q [NUM_BINS];
  longint    sin_q [NUM_BINS];
  logic [RANGE_W-1:0] bin_store [NUM_BINS];
  longint    lo_hgt, hi_hgt;
  logic [RANGE_W-1:0] empty_val;

  scan_res_t expected_q[$];
  stim_row_t table_q[$];
  int        errors, n_req, n_res, n_read, n_upd;
  bit        cur_fixed;
  scan_res_t cur_res;
  bit        hold_long;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint qdiv(longint a, longint b);
    return (a * b) / ONE_Q30;
  endfunction

  function automatic void make_edges();
    longint ang, b, b2, ts, tc, ss, cs, m;
    cos_q[0] = ONE_Q30;
    sin_q[0] = 0;
    for (int k = 1; k < NUM_BINS; k++) begin
      ang = (longint'(k) * PI_Q30) / NUM_BINS;
      b   = ang - HALF_PI_Q30;
      b2  = qdiv(b, b);
      ts = b; tc = ONE_Q30; ss = 0; cs = 0;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        m  = 2 * n;
        ss += ts;
        cs += tc;
        ts = -qdiv(ts, b2) / ((m + 2) * (m + 3));
        tc = -qdiv(tc, b2) / ((m + 1) * (m + 2));
      end
      cos_q[k] = -ss;
      sin_q[k] = cs;
    end
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, t;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic scan_res_t scan_point(logic op, logic signed [COORD_W-1:0] xs,
                                           logic signed [COORD_W-1:0] ys,
                                           logic signed [COORD_W-1:0] zs, logic pv,
                                           logic [BIN_W-1:0] rb);
    scan_res_t o;
    longint x, z, h, zz, r;
    int idx;
    o.bin_index = '0;
    o.range_mm  = '0;
    x = xs; z = zs; h = -longint'(ys);
    if (op) begin
      o.status    = ST_READ;
      o.bin_index = rb;
      if (rb < NUM_BINS) begin
        o.range_mm    = bin_store[rb];
        bin_store[rb] = empty_val;
      end else begin
        o.range_mm = empty_val;
      end
    end else if (!pv) begin
      o.status = ST_INVALID;
    end else if (h < lo_hgt || h > hi_hgt) begin
      o.status = ST_HEIGHT;
    end else if (z < 0) begin
      o.status = ST_ANGLE;
    end else begin
      zz  = (x == 0 && z == 0) ? 1 : z;
      idx = 0;
      for (int k = 1; k < NUM_BINS; k++)
        if (zz * cos_q[k] - x * sin_q[k] >= 0) idx++;
      r = floor_sqrt(x * x + z * z);
      o.bin_index = BIN_W'(idx);
      o.range_mm  = (r > 65535) ? 16'hFFFF : r[15:0];
      if (longint'(bin_store[idx]) > r) begin
        bin_store[idx] = r[15:0];
        o.status = ST_UPDATED;
      end else begin
        o.status = ST_FARTHER;
      end
    end
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // request side bookkeeping and shadow register writes
  always @(posedge clk_i) begin
    scan_res_t p;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_HEIGHT:  lo_hgt = longint'($signed(cfg_data_i));
        CFG_MAX_HEIGHT:  hi_hgt = longint'($signed(cfg_data_i));
        CFG_EMPTY_RANGE: empty_val = cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      p = scan_point(req_if.opcode, req_if.x_mm, req_if.y_mm, req_if.z_mm,
                     req_if.point_valid, req_if.read_bin);
      expected_q.push_back(cur_fixed ? cur_res : p);
      n_req++;
      if (p.status == ST_READ) n_read++;
      if (p.status == ST_UPDATED) n_upd++;
    end
  end

  always @(posedge clk_i) begin
    scan_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_res++;
      if (expected_q.size() == 0) begin
        report("unexpected result, status", res_if.status, -1);
      end else begin
        e = expected_q.pop_front();
        if (res_if.status !== e.status) report("status", res_if.status, e.status);
        if (res_if.bin_index !== e.bin_index)
          report("bin_index", res_if.bin_index, e.bin_index);
        if (res_if.range_mm !== e.range_mm)
          report("range_mm", res_if.range_mm, e.range_mm);
      end
    end
  end

  // result receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall, cnt;
    bit quiet;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    cnt = 0;
    forever begin
      if (cnt % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      cnt++;
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (hold_long) begin
        stall = LONG_HOLD;
        hold_long = 1'b0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // one request through the valid/ready handshake; valid stays up when gap is 0
  task automatic send(stim_row_t r, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= r.opcode;
    req_if.x_mm        <= r.x;
    req_if.y_mm        <= r.y;
    req_if.z_mm        <= r.z;
    req_if.point_valid <= r.pvalid;
    req_if.read_bin    <= r.rbin;
    cur_fixed          <= r.fixed;
    cur_res            <= r.res;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic stim_row_t pt(int x, int y, int z, logic pv);
    stim_row_t r;
    r = '{kind: ROW_REQ, opcode: 1'b0, x: COORD_W'(x), y: COORD_W'(y), z: COORD_W'(z),
          pvalid: pv, rbin: BIN_W'($urandom), cidx: '0, cval: '0, fixed: 1'b0,
          res: '{ST_UPDATED, '0, '0}};
    return r;
  endfunction

  function automatic stim_row_t rd(int b);
    stim_row_t r;
    r = pt(int'($urandom), int'($urandom), int'($urandom), 1'($urandom));
    r.opcode = 1'b1;
    r.rbin   = BIN_W'(b);
    return r;
  endfunction

  function automatic stim_row_t cfg(logic [CFG_IDX_W-1:0] i, int v);
    stim_row_t r;
    r = pt(0, 0, 0, 1'b1);
    r.kind = ROW_CFG;
    r.cidx = i;
    r.cval = CFG_W'(v);
    return r;
  endfunction

  function automatic stim_row_t fx(stim_row_t r, status_e s, int b, int rng);
    r.fixed = 1'b1;
    r.res   = '{s, BIN_W'(b), RANGE_W'(rng)};
    return r;
  endfunction

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return int'($urandom_range(0, 6000)) - 3000;
    if (sel < 8) return int'($urandom_range(0, 40000)) - 20000;
    return int'($signed(18'($urandom)));
  endfunction

  function automatic stim_row_t rand_req();
    stim_row_t r;
    longint h;
    if ($urandom_range(0, 3) == 0)
      return rd(($urandom_range(0, 9) == 0) ? int'($urandom_range(NUM_BINS, 511))
                                           : int'($urandom_range(0, NUM_BINS - 1)));
    r = pt(rand_coord(), int'($signed(18'($urandom))), rand_coord(),
           $urandom_range(0, 12) != 0);
    // mostly heights inside the band so points reach the binning
    if (lo_hgt <= hi_hgt && $urandom_range(0, 4) != 0) begin
      h = lo_hgt + $urandom_range(0, int'(hi_hgt - lo_hgt));
      if (h < -131071) h = -131071;
      r.y = COORD_W'(-h);
    end
    return r;
  endfunction

  initial begin
    int phase_lo[6] = '{-131072, 0,     -500, 100,  -131072, -2000};
    int phase_hi[6] = '{131071,  0,     2000, -100, 131071,  2000};
    int phase_em[6] = '{11000,   65535, 0,    5000, 65535,   3000};
    bit quiet;
    make_edges();
    lo_hgt    = MIN_HEIGHT_RST;
    hi_hgt    = MAX_HEIGHT_RST;
    empty_val = EMPTY_RANGE_RST;
    foreach (bin_store[i]) bin_store[i] = EMPTY_RANGE_RST;
    errors = 0; n_req = 0; n_res = 0; n_read = 0; n_upd = 0;
    hold_long = 1'b0;
    cur_fixed = 1'b0;
    cur_res   = '{ST_UPDATED, '0, '0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    req_if.valid = 1'b0; req_if.opcode = 1'b0; req_if.x_mm = '0; req_if.y_mm = '0;
    req_if.z_mm = '0; req_if.point_valid = 1'b0; req_if.read_bin = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    table_q.push_back(fx(rd(0),   ST_READ, 0,   11000));
    table_q.push_back(fx(rd(511), ST_READ, 511, 11000));
    table_q.push_back(fx(rd(359), ST_READ, 359, 11000));
    table_q.push_back(fx(pt(131071, -131072, 131071, 1'b0), ST_INVALID, 0, 0));
    table_q.push_back(fx(pt(5, 0, -1, 1'b1), ST_ANGLE, 0, 0));
    table_q.push_back(pt(0, 0, 0, 1'b1));  // origin counts as straight ahead
    table_q.push_back(fx(pt(1000, 0, 0, 1'b1),  ST_UPDATED, 0,   1000));
    table_q.push_back(fx(pt(-1000, 0, 0, 1'b1), ST_UPDATED, 359, 1000));
    table_q.push_back(fx(pt(-131072, 0, 0, 1'b1), ST_FARTHER, 359, 65535));
    table_q.push_back(pt(131071, -131072, 131071, 1'b1));
    table_q.push_back(pt(131071, -131072, 131071, 1'b1));
    table_q.push_back(pt(0, 131071, 5000, 1'b1));
    table_q.push_back(pt(-131072, 131071, 131071, 1'b1));
    table_q.push_back(fx(rd(0), ST_READ, 0, 1000));
    table_q.push_back(fx(rd(0), ST_READ, 0, 11000));
    table_q.push_back(cfg(CFG_MIN_HEIGHT, 0));
    table_q.push_back(cfg(CFG_MAX_HEIGHT, 100));
    table_q.push_back(cfg(CFG_EMPTY_RANGE, 65535));
    table_q.push_back(fx(pt(10, -101, 10, 1'b1), ST_HEIGHT, 0, 0));
    table_q.push_back(fx(pt(10, 1, 10, 1'b1),    ST_HEIGHT, 0, 0));
    table_q.push_back(pt(10, -100, 10, 1'b1));
    table_q.push_back(pt(-7, 0, 3, 1'b1));
    table_q.push_back(fx(rd(400), ST_READ, 400, 65535));

    foreach (table_q[i]) begin
      if (table_q[i].kind == ROW_CFG) begin
        req_if.valid <= 1'b0;
        write_reg(table_q[i].cidx, table_q[i].cval);
      end else begin
        send(table_q[i], $urandom_range(0, 3));
      end
    end
    req_if.valid <= 1'b0;
    cur_fixed    <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      req_if.valid <= 1'b0;
      write_reg(CFG_MIN_HEIGHT, phase_lo[ph]);
      write_reg(CFG_MAX_HEIGHT, phase_hi[ph]);
      write_reg(CFG_EMPTY_RANGE, phase_em[ph]);
      for (int i = 0; i < 270; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (ph == 1 && i == 20) hold_long = 1'b1;
        if (ph == 2 && i == 100) begin
          // let the pipe run dry mid-phase
          req_if.valid <= 1'b0;
          @(posedge clk_i);
          while (expected_q.size() != 0) @(posedge clk_i);
        end
        send(rand_req(), quiet ? 0 : $urandom_range(0, 14));
      end
    end
    req_if.valid <= 1'b0;

    wait_idle();
    $display("covered %0d requests (%0d reads, %0d bin updates), %0d results checked",
             n_req, n_read, n_upd, n_res);
    $display("six register settings incl. empty range 0/65535 and an empty height band");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
